// ----- rtl/core/ldq_pkg.sv -----
// Shared types and constants for the linear double-ended queue.
`default_nettype none

package ldq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned STS_W  = 2;
  localparam int unsigned OCC_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_REAR  = 2'd0,
    CMD_POP_FRONT  = 2'd1,
    CMD_POP_REAR   = 2'd2,
    CMD_PUSH_FRONT = 2'd3
  } cmd_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK       = 2'd0,
    STS_FULL     = 2'd1,
    STS_EMPTY    = 2'd2,
    STS_NO_FRONT = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/core/ldq_if.sv -----
// Valid/ready channel interfaces for queue commands and responses.
`default_nettype none

interface ldq_req_if;
  logic                               valid;
  logic                               ready;
  logic        [ldq_pkg::CMD_W-1:0]   command;
  logic signed [ldq_pkg::DATA_W-1:0]  value_in;

  modport source (output valid, command, value_in, input ready);
  modport sink   (input valid, command, value_in, output ready);
endinterface

interface ldq_rsp_if;
  logic                               valid;
  logic                               ready;
  logic        [ldq_pkg::STS_W-1:0]   status;
  logic signed [ldq_pkg::DATA_W-1:0]  value_out;
  logic        [ldq_pkg::OCC_W-1:0]   occupancy;

  modport source (output valid, status, value_out, occupancy, input ready);
  modport sink   (input valid, status, value_out, occupancy, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ldq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ldq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/linear_double_ended_queue.sv -----
// Top level of the linear (non-wrapping) double-ended queue.
//
//   channel | dir | fields                           | transaction
//   req_i   | in  | command, value_in                | valid & ready
//   rsp_o   | out | status, value_out, occupancy     | valid & ready
//
// Pushes and failed commands load the response register on acceptance; a
// successful pop goes through the element RAM read register and S_READ first.
// The response register decouples the sides: a new command is taken in the
// cycle the previous response leaves. Reset clears both indices and the
// control state; the element RAM needs no clearing.
`default_nettype none

module linear_double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ldq_req_if.sink    req_i,
  ldq_rsp_if.source  rsp_o
);

  localparam int unsigned IDX_W  = $clog2(DEPTH + 1);
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] IDX_FULL = IDX_W'(DEPTH);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);

  ldq_pkg::state_e state_q, state_d;
  logic [IDX_W-1:0] front_q, front_d;
  logic [IDX_W-1:0] rear_q, rear_d;

  logic                         rsp_valid_q, rsp_valid_d;
  ldq_pkg::status_e             status_q, status_d;
  logic [ldq_pkg::DATA_W-1:0]   value_q, value_d;
  logic [ldq_pkg::OCC_W-1:0]    occ_q, occ_d;
  logic                         load_rsp;

  logic                         req_fire;
  logic                         rsp_free;
  logic                         ram_we, ram_re;
  logic [ADDR_W-1:0]            ram_waddr, ram_raddr;
  logic [ldq_pkg::DATA_W-1:0]   ram_rdata;
  logic [IDX_W-1:0]             front_dec, rear_dec;

  assign rsp_free  = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ldq_pkg::S_IDLE) && rsp_free;
  assign req_fire  = req_i.valid && req_i.ready;
  assign front_dec = front_q - IDX_ONE;
  assign rear_dec  = rear_q - IDX_ONE;

  ldq_ram #(
    .WIDTH (ldq_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (req_i.value_in),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    rear_d      = rear_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = rear_q[ADDR_W-1:0];
    ram_raddr   = front_q[ADDR_W-1:0];
    load_rsp    = 1'b0;
    status_d    = ldq_pkg::STS_OK;
    value_d     = '0;

    unique case (state_q)
      ldq_pkg::S_IDLE: begin
        if (req_fire) begin
          load_rsp = 1'b1;
          unique case (ldq_pkg::cmd_e'(req_i.command))
            ldq_pkg::CMD_PUSH_REAR: begin
              if (rear_q == IDX_FULL) begin
                status_d = ldq_pkg::STS_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = rear_q[ADDR_W-1:0];
                rear_d    = rear_q + IDX_ONE;
              end
            end
            ldq_pkg::CMD_POP_FRONT: begin
              if (front_q == rear_q) begin
                status_d = ldq_pkg::STS_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = front_q[ADDR_W-1:0];
                front_d   = front_q + IDX_ONE;
                load_rsp  = 1'b0;
                state_d   = ldq_pkg::S_READ;
              end
            end
            ldq_pkg::CMD_POP_REAR: begin
              if (front_q == rear_q) begin
                status_d = ldq_pkg::STS_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = rear_dec[ADDR_W-1:0];
                rear_d    = rear_dec;
                load_rsp  = 1'b0;
                state_d   = ldq_pkg::S_READ;
              end
            end
            ldq_pkg::CMD_PUSH_FRONT: begin
              if (front_q == '0) begin
                status_d = ldq_pkg::STS_NO_FRONT;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = front_dec[ADDR_W-1:0];
                front_d   = front_dec;
              end
            end
            default: begin
              status_d = ldq_pkg::STS_OK;
            end
          endcase
        end
      end
      ldq_pkg::S_READ: begin
        // Read data holds in the RAM register until the response slot frees.
        if (rsp_free) begin
          load_rsp = 1'b1;
          value_d  = ram_rdata;
          state_d  = ldq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ldq_pkg::S_IDLE;
      end
    endcase

    occ_d = ldq_pkg::OCC_W'(rear_d - front_d);

    if (load_rsp) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ldq_pkg::S_IDLE;
      front_q     <= '0;
      rear_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      rear_q      <= rear_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_rsp) begin
      status_q <= status_d;
      value_q  <= value_d;
      occ_q    <= occ_d;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.status    = status_q;
  assign rsp_o.value_out = value_q;
  assign rsp_o.occupancy = occ_q;

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the linear double-ended queue: directed table, then random.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned Q_DEPTH = 16;

  typedef struct packed {
    ldq_pkg::status_e                   status;
    logic signed [ldq_pkg::DATA_W-1:0]  value_out;
    logic        [ldq_pkg::OCC_W-1:0]   occupancy;
  } queue_result_t;

  typedef struct packed {
    ldq_pkg::cmd_e                      command;
    logic signed [ldq_pkg::DATA_W-1:0]  value_in;
    logic                               typed;
    queue_result_t                      result;
  } dir_row_t;

  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} mix_mode_e;

  logic clk_i;
  logic rst_ni;

  ldq_req_if req_if ();
  ldq_rsp_if rsp_if ();

  linear_double_ended_queue #(.DEPTH(Q_DEPTH)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow copy of the queue contents and both indices
  logic signed [ldq_pkg::DATA_W-1:0] shadow_mem [Q_DEPTH];
  logic        [ldq_pkg::OCC_W-1:0]  shadow_front;
  logic        [ldq_pkg::OCC_W-1:0]  shadow_rear;

  queue_result_t pending_results [$];
  int unsigned   fail_count;
  bit            idle_on;

  // Directed table: rows with typed = 1 carry the expected result, the rest are predicted
  dir_row_t dir_rows [27] = '{
    '{ldq_pkg::CMD_POP_FRONT,  32'sd0,         1'b1, '{ldq_pkg::STS_EMPTY,    32'sd0, 5'd0}},
    '{ldq_pkg::CMD_POP_REAR,   32'sd0,         1'b1, '{ldq_pkg::STS_EMPTY,    32'sd0, 5'd0}},
    '{ldq_pkg::CMD_PUSH_FRONT, 32'sh1234_5678, 1'b1, '{ldq_pkg::STS_NO_FRONT, 32'sd0, 5'd0}},
    '{ldq_pkg::CMD_PUSH_REAR,  32'sh7FFF_FFFF, 1'b1, '{ldq_pkg::STS_OK,       32'sd0, 5'd1}},
    '{ldq_pkg::CMD_PUSH_REAR,  32'sh8000_0000, 1'b1, '{ldq_pkg::STS_OK,       32'sd0, 5'd2}},
    '{ldq_pkg::CMD_POP_FRONT,  32'sd0,         1'b1,
      '{ldq_pkg::STS_OK, 32'sh7FFF_FFFF, 5'd1}},
    '{ldq_pkg::CMD_PUSH_FRONT, 32'shFFFF_FFFF, 1'b1, '{ldq_pkg::STS_OK,       32'sd0, 5'd2}},
    '{ldq_pkg::CMD_POP_REAR,   32'sd0,         1'b1,
      '{ldq_pkg::STS_OK, 32'sh8000_0000, 5'd1}},
    '{ldq_pkg::CMD_POP_REAR,   32'sd0,         1'b1,
      '{ldq_pkg::STS_OK, 32'shFFFF_FFFF, 5'd0}},
    '{ldq_pkg::CMD_PUSH_REAR,  32'shA5A5_A5A5, 1'b0, '{ldq_pkg::STS_OK,       32'sd0, 5'd0}},
    '{ldq_pkg::CMD_PUSH_REAR,  32'sh5A5A_5A5A, 1'b0, '{ldq_pkg::STS_OK,       32'sd0, 5'd0}},
    '{ldq_pkg::CMD_PUSH_REAR,  32'sh0000_0001, 1'b0, '{ldq_pkg::STS_OK,       32'sd0, 5'd0}},
    '{ldq_pkg::CMD_PUSH_REAR,  32'sh8000_0001, 1'b0, '{ldq_pkg::STS_OK,       32'sd0, 5'd0}},
    '{ldq_pkg::CMD_PUSH_REAR,  32'sh0F0F_0F0F, 1'b0, '{ldq_pkg::STS_OK,       32'sd0, 5'd0}},
    '{ldq_pkg::CMD_PUSH_REAR,  32'shF0F0_F0F0, 1'b0, '{ldq_pkg::STS_OK,       32'sd0, 5'd0}},
    '{ldq_pkg::CMD_PUSH_REAR,  32'sh3333_3333, 1'b0, '{ldq_pkg::STS_OK,       32'sd0, 5'd0}},
    '{ldq_pkg::CMD_PUSH_REAR,  32'shCCCC_CCCC, 1'b0, '{ldq_pkg::STS_OK,       32'sd0, 5'd0}},
    '{ldq_pkg::CMD_PUSH_REAR,  32'sh0000_0000, 1'b0, '{ldq_pkg::STS_OK,       32'sd0, 5'd0}},
    '{ldq_pkg::CMD_PUSH_REAR,  32'shFFFF_FFFE, 1'b0, '{ldq_pkg::STS_OK,       32'sd0, 5'd0}},
    '{ldq_pkg::CMD_PUSH_REAR,  32'sh7FFF_FFFE, 1'b0, '{ldq_pkg::STS_OK,       32'sd0, 5'd0}},
    '{ldq_pkg::CMD_PUSH_REAR,  32'sh1111_1111, 1'b0, '{ldq_pkg::STS_OK,       32'sd0, 5'd0}},
    '{ldq_pkg::CMD_PUSH_REAR,  32'shEEEE_EEEE, 1'b0, '{ldq_pkg::STS_OK,       32'sd0, 5'd0}},
    '{ldq_pkg::CMD_PUSH_REAR,  32'sh6969_9696, 1'b0, '{ldq_pkg::STS_OK,       32'sd0, 5'd0}},
    '{ldq_pkg::CMD_PUSH_REAR,  32'sh9696_6969, 1'b0, '{ldq_pkg::STS_OK,       32'sd0, 5'd0}},
    '{ldq_pkg::CMD_PUSH_REAR,  32'sh0123_4567, 1'b0, '{ldq_pkg::STS_OK,       32'sd0, 5'd0}},
    '{ldq_pkg::CMD_PUSH_REAR,  32'sh7654_3210, 1'b1, '{ldq_pkg::STS_FULL,     32'sd0, 5'd16}},
    '{ldq_pkg::CMD_PUSH_FRONT, 32'shDEAD_BEEF, 1'b1, '{ldq_pkg::STS_NO_FRONT, 32'sd0, 5'd16}}
  };

  // Apply one command to the shadow queue and return the response it should produce
  function automatic queue_result_t predict_queue(
      input ldq_pkg::cmd_e cmd, input logic signed [ldq_pkg::DATA_W-1:0] val);
    queue_result_t res;
    res.status    = ldq_pkg::STS_OK;
    res.value_out = '0;
    case (cmd)
      ldq_pkg::CMD_PUSH_REAR: begin
        if (shadow_rear >= Q_DEPTH) begin
          res.status = ldq_pkg::STS_FULL;
        end else begin
          shadow_mem[shadow_rear] = val;
          shadow_rear = shadow_rear + 1'b1;
        end
      end
      ldq_pkg::CMD_POP_FRONT: begin
        if (shadow_front == shadow_rear) begin
          res.status = ldq_pkg::STS_EMPTY;
        end else begin
          res.value_out = shadow_mem[shadow_front];
          shadow_front = shadow_front + 1'b1;
        end
      end
      ldq_pkg::CMD_POP_REAR: begin
        if (shadow_front == shadow_rear) begin
          res.status = ldq_pkg::STS_EMPTY;
        end else begin
          shadow_rear = shadow_rear - 1'b1;
          res.value_out = shadow_mem[shadow_rear];
        end
      end
      default: begin
        if (shadow_front == '0) begin
          res.status = ldq_pkg::STS_NO_FRONT;
        end else begin
          shadow_front = shadow_front - 1'b1;
          shadow_mem[shadow_front] = val;
        end
      end
    endcase
    res.occupancy = shadow_rear - shadow_front;
    return res;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction
  task automatic send_command(input ldq_pkg::cmd_e cmd,
                              input logic signed [ldq_pkg::DATA_W-1:0] val,
                              input logic typed, input queue_result_t typed_res);
    queue_result_t res;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.command  <= cmd;
    req_if.value_in <= val;
    do @(posedge clk_i); while (!req_if.ready);
    res = predict_queue(cmd, val);
    pending_results.push_back(typed ? typed_res : res);
    @(negedge clk_i);
  endtask

  function automatic logic signed [ldq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  function automatic ldq_pkg::cmd_e pick_command(input mix_mode_e mode);
    bit push_side;
    bit front_end;
    front_end = 1'($urandom_range(0, 1));
    case (mode)
      MODE_FILL:  push_side = ($urandom_range(0, 9) < 8);
      MODE_DRAIN: push_side = ($urandom_range(0, 9) < 2);
      default:    push_side = 1'($urandom_range(0, 1));
    endcase
    if (push_side) return front_end ? ldq_pkg::CMD_PUSH_FRONT : ldq_pkg::CMD_PUSH_REAR;
    return front_end ? ldq_pkg::CMD_POP_FRONT : ldq_pkg::CMD_POP_REAR;
  endfunction

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Response side: stall in random bursts while idling is enabled
  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!idle_on) begin
        stall_left = 0;
        rsp_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : rsp_check
    queue_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected response: status %0d value_out %0d occupancy %0d",
               rsp_if.status, rsp_if.value_out, rsp_if.occupancy);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_if.status);
          fail_count++;
        end
        if (rsp_if.value_out !== want.value_out) begin
          $error("value_out: expected %0d, got %0d", want.value_out, rsp_if.value_out);
          fail_count++;
        end
        if (rsp_if.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, rsp_if.occupancy);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("linear_double_ended_queue test failed");
    $finish;
  end

  initial begin
    mix_mode_e   mode;
    int unsigned run_left;
    int unsigned n_random;
    queue_result_t none;
    n_random        = 500;
    none            = '0;
    fail_count      = 0;
    idle_on         = 1'b1;
    shadow_front    = '0;
    shadow_rear     = '0;
    foreach (shadow_mem[i]) shadow_mem[i] = '0;
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.command  = ldq_pkg::CMD_PUSH_REAR;
    req_if.value_in = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      send_command(dir_rows[i].command, dir_rows[i].value_in,
                   dir_rows[i].typed, dir_rows[i].result);
    end

    // Random walk in runs that lean toward filling, draining or neither
    mode     = MODE_MIX;
    run_left = 0;
    for (int unsigned n = 0; n < n_random; n++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(8, 24);
        case ($urandom_range(0, 2))
          0:       mode = MODE_FILL;
          1:       mode = MODE_DRAIN;
          default: mode = MODE_MIX;
        endcase
      end
      run_left--;
      if (n == n_random - 100) idle_on = 1'b0;
      send_command(pick_command(mode), pick_value(), 1'b0, none);
    end
    req_if.valid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (4) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d responses never arrived", pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("linear_double_ended_queue test passed");
    end else begin
      $display("linear_double_ended_queue test failed");
    end
    $finish;
  end

endmodule
